/* rtl/lzss_flag_word_decompressor_top_defines.svh */
// ----------------------------------------------------------------------------
// LZSS decompressor assertion macros
// Concurrent assertion wrappers; defining ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef LZSS_FLAG_WORD_DECOMPRESSOR_TOP_DEFINES_SVH
`define LZSS_FLAG_WORD_DECOMPRESSOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Property holds at every clock edge outside reset
`define LZSS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lzss assertion failed");
// Consequent holds in the same cycle as the antecedent
`define LZSS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzss implication failed");
`else
`define LZSS_ASSERT(name, clk, rst_n, prop)
`define LZSS_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/lzss_pkg.sv */
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Shared widths, constants and the structs passed between the submodules.
// ----------------------------------------------------------------------------
package lzss_pkg;

  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned HIST_DEPTH       = 256;
  localparam int unsigned HIST_AW          = $clog2(HIST_DEPTH);
  localparam int unsigned BYTES_PER_RESULT = 4;
  localparam int unsigned OUT_LANES        = 4;
  localparam int unsigned CNT_W            = 3;
  localparam int unsigned SIZE_W           = 32;
  localparam int unsigned FLAG_W           = 16;
  localparam int unsigned FLAG_IDX_W       = 4;
  localparam int unsigned HDR_POS_W        = 3;

  localparam logic [HDR_POS_W-1:0]  HDR_SKIP_BYTES = 3'd4;
  localparam logic [HDR_POS_W-1:0]  SIZE_BYTES     = 3'd4;
  localparam logic [FLAG_IDX_W-1:0] FLAG_LAST_IDX  = 4'd15;

  // Token handed from the parser to the copy engine
  typedef struct packed {
    logic                valid;
    logic                literal;
    logic [BYTE_W-1:0]   data;
    logic [BYTE_W-1:0]   offset;
    logic [BYTE_W-1:0]   length;
    logic [SIZE_W-1:0]   base;
    logic [SIZE_W-1:0]   target;
  } tok_cmd_t;

  // History memory access from the copy engine
  typedef struct packed {
    logic               we;
    logic [HIST_AW-1:0] waddr;
    logic [BYTE_W-1:0]  wdata;
    logic               re;
    logic [HIST_AW-1:0] raddr;
  } hist_req_t;

  // One packed result
  typedef struct packed {
    logic [OUT_LANES-1:0][BYTE_W-1:0] data;
    logic [CNT_W-1:0]                 count;
    logic                             last;
    logic                             done;
  } res_t;

endpackage

/* rtl/lzss_if.sv */
// ----------------------------------------------------------------------------
// LZSS decompressor channel interfaces
// Valid/ready channels for compressed input bytes and packed output results.
// ----------------------------------------------------------------------------
interface lzss_in_if;
  logic                          valid;
  logic                          ready;
  logic [lzss_pkg::BYTE_W-1:0]   in_byte;
  logic                          new_stream;

  modport source (output valid, output in_byte, output new_stream, input ready);
  modport sink   (input valid, input in_byte, input new_stream, output ready);
endinterface

interface lzss_out_if;
  logic                          valid;
  logic                          ready;
  logic [lzss_pkg::BYTE_W-1:0]   data_0;
  logic [lzss_pkg::BYTE_W-1:0]   data_1;
  logic [lzss_pkg::BYTE_W-1:0]   data_2;
  logic [lzss_pkg::BYTE_W-1:0]   data_3;
  logic [lzss_pkg::CNT_W-1:0]    byte_count;
  logic                          run_last;
  logic                          stream_done;

  modport source (output valid, output data_0, output data_1, output data_2,
                  output data_3, output byte_count, output run_last,
                  output stream_done, input ready);
  modport sink   (input valid, input data_0, input data_1, input data_2,
                  input data_3, input byte_count, input run_last,
                  input stream_done, output ready);
endinterface

/* rtl/lzss_flag_word_decompressor_top.sv */
// A literal's byte is written to the history and to lane 0, then moved to the output register
// once that is free; a match's bytes are read from the history one by one, landed in the lanes
// and pushed as a group (a lane group refills only once it has left).
// Header, flag and offset bytes and zero-length matches are taken straight away; a literal or a
// match holds the next byte back until the token's last result has gone to the output register.
// Reset (async, active low) and the start of a stream clear the history at once.
`include "lzss_flag_word_decompressor_top_defines.svh"
// ----------------------------------------------------------------------------
// LZSS flag-word decompressor
// Byte-serial parser, history-memory copy engine and output packing.
// ----------------------------------------------------------------------------
module lzss_flag_word_decompressor_top #(
  parameter int unsigned BytesPerResult = lzss_pkg::BYTES_PER_RESULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lzss_in_if.sink     in_i,
  lzss_out_if.source  out_o
);
  import lzss_pkg::*;

  localparam int unsigned Lanes = (BytesPerResult > OUT_LANES) ? OUT_LANES :
                                  ((BytesPerResult < 1) ? 1 : BytesPerResult);

  tok_cmd_t           cmd;
  hist_req_t          hreq;
  res_t               res;
  logic               res_valid;
  logic               hist_clear;
  logic               eng_idle;
  logic [BYTE_W-1:0]  hist_rdata;

  lzss_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_byte_i    (in_i.in_byte),
    .new_stream_i (in_i.new_stream),
    .eng_idle_i   (eng_idle),
    .clear_o      (hist_clear),
    .cmd_o        (cmd)
  );

  lzss_hist u_hist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (hist_clear),
    .req_i   (hreq),
    .rdata_o (hist_rdata)
  );

  lzss_copy #(
    .BytesPerResult (BytesPerResult)
  ) u_copy (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (hist_clear),
    .cmd_i        (cmd),
    .idle_o       (eng_idle),
    .hist_o       (hreq),
    .hist_rdata_i (hist_rdata),
    .res_valid_o  (res_valid),
    .res_ready_i  (out_o.ready),
    .res_o        (res)
  );

  // Drive the output channel
  assign out_o.valid       = res_valid;
  assign out_o.data_0      = res.data[0];
  assign out_o.data_1      = res.data[1];
  assign out_o.data_2      = res.data[2];
  assign out_o.data_3      = res.data[3];
  assign out_o.byte_count  = res.count;
  assign out_o.run_last    = res.last;
  assign out_o.stream_done = res.done;

  // Tokens reach the copy engine only while it is idle
  `LZSS_ASSERT_IMPL(a_cmd_when_idle, clk_i, rst_ni, cmd.valid, eng_idle)
  // A stream restart never collides with a history write
  `LZSS_ASSERT(a_no_write_on_clear, clk_i, rst_ni, !(hist_clear && hreq.we))
  // Every result carries between one and a full group of bytes
  `LZSS_ASSERT_IMPL(a_count_range, clk_i, rst_ni, out_o.valid, (out_o.byte_count != '0) && (out_o.byte_count <= CNT_W'(Lanes)))

endmodule

/* rtl/lzss_hist.sv */
// ----------------------------------------------------------------------------
// LZSS history memory
// 256-byte window, one write and one registered read per cycle. Per-entry
// valid bits make a cleared or never-written entry read as zero.
// ----------------------------------------------------------------------------
module lzss_hist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  lzss_pkg::hist_req_t           req_i,
  output logic [lzss_pkg::BYTE_W-1:0]   rdata_o
);
  import lzss_pkg::*;

  logic [BYTE_W-1:0]     mem_q [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] valid_q;
  logic [BYTE_W-1:0]     rdata_q;
  logic                  rvalid_q;

  // Storage array: write and read-before-write
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  // Track written entries; drop all on stream restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (req_i.re) begin
        rvalid_q <= valid_q[req_i.raddr];
      end
      if (clear_i) begin
        valid_q <= '0;
      end else if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

/* rtl/lzss_parser.sv */
// ----------------------------------------------------------------------------
// LZSS stream parser
// Walks the header, size and flag words, and turns each completed token into
// a command for the copy engine. Tracks the produced count and end of stream.
// ----------------------------------------------------------------------------
module lzss_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lzss_pkg::BYTE_W-1:0]   in_byte_i,
  input  logic                          new_stream_i,
  input  logic                          eng_idle_i,
  output logic                          clear_o,
  output lzss_pkg::tok_cmd_t            cmd_o
);
  import lzss_pkg::*;

  typedef enum logic [5:0] {
    PH_SKIP   = 6'b000001,
    PH_SIZE   = 6'b000010,
    PH_FLAGS  = 6'b000100,
    PH_TOKEN  = 6'b001000,
    PH_LENGTH = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_e;

  phase_e                phase_q, phase_d, phase_c;
  logic [HDR_POS_W-1:0]  pos_q, pos_d, pos_c, pos_inc;
  logic [SIZE_W-1:0]     target_q, target_d, target_c;
  logic [SIZE_W-1:0]     prod_q, prod_d, prod_c, prod_next;
  logic [SIZE_W:0]       prod_sum;
  logic [FLAG_W-1:0]     flag_q, flag_d, flag_c;
  logic [FLAG_IDX_W-1:0] idx_q, idx_d, idx_c;
  logic [BYTE_W-1:0]     off_q, off_d, off_c;
  logic                  done_q, done_d, done_c;
  logic                  accept;
  logic                  tok_done;
  logic                  tok_lit;
  logic [BYTE_W-1:0]     tok_n;

  assign in_ready_o = eng_idle_i;
  assign accept     = in_valid_i & in_ready_o;
  assign clear_o    = accept & new_stream_i;

  // Start from a clean parse when the transaction opens a new stream
  always_comb begin
    if (clear_o) begin
      phase_c  = PH_SKIP;
      pos_c    = '0;
      target_c = '0;
      prod_c   = '0;
      flag_c   = '0;
      idx_c    = '0;
      off_c    = '0;
      done_c   = 1'b0;
    end else begin
      phase_c  = phase_q;
      pos_c    = pos_q;
      target_c = target_q;
      prod_c   = prod_q;
      flag_c   = flag_q;
      idx_c    = idx_q;
      off_c    = off_q;
      done_c   = done_q;
    end
  end

  assign pos_inc   = pos_c + HDR_POS_W'(1);
  assign prod_sum  = {1'b0, prod_c} + (SIZE_W + 1)'(tok_n);
  assign prod_next = prod_sum[SIZE_W] ? '1 : prod_sum[SIZE_W-1:0];

  // Parse one byte
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    target_d = target_q;
    prod_d   = prod_q;
    flag_d   = flag_q;
    idx_d    = idx_q;
    off_d    = off_q;
    done_d   = done_q;
    tok_done = 1'b0;
    tok_lit  = 1'b0;
    tok_n    = '0;

    if (accept) begin
      phase_d  = phase_c;
      pos_d    = pos_c;
      target_d = target_c;
      prod_d   = prod_c;
      flag_d   = flag_c;
      idx_d    = idx_c;
      off_d    = off_c;
      done_d   = done_c;

      if (!done_c) begin
        case (phase_c)
          PH_SKIP: begin
            pos_d = pos_inc;
            if (pos_inc >= HDR_SKIP_BYTES) begin
              phase_d = PH_SIZE;
              pos_d   = '0;
            end
          end
          PH_SIZE: begin
            if (pos_c == '0) begin
              target_d = '0;
            end
            target_d[{pos_c[1:0], 3'b000} +: BYTE_W] = in_byte_i;
            pos_d = pos_inc;
            if (pos_inc >= SIZE_BYTES) begin
              phase_d = PH_FLAGS;
              pos_d   = '0;
            end
          end
          PH_FLAGS: begin
            if (pos_c == '0) begin
              flag_d = {{(FLAG_W - BYTE_W){1'b0}}, in_byte_i};
              pos_d  = HDR_POS_W'(1);
            end else begin
              flag_d  = {in_byte_i, flag_c[BYTE_W-1:0]};
              pos_d   = '0;
              idx_d   = '0;
              phase_d = PH_TOKEN;
            end
          end
          PH_TOKEN: begin
            if (flag_c[idx_c]) begin
              off_d   = in_byte_i;
              phase_d = PH_LENGTH;
            end else begin
              tok_done = 1'b1;
              tok_lit  = 1'b1;
              tok_n    = BYTE_W'(1);
            end
          end
          PH_LENGTH: begin
            tok_done = 1'b1;
            tok_n    = in_byte_i;
          end
          default: begin
            done_d  = 1'b1;
            phase_d = PH_DONE;
          end
        endcase

        // Close the token: count bytes, advance the flag bit, test the size
        if (tok_done) begin
          prod_d = prod_next;
          if (idx_c >= FLAG_LAST_IDX) begin
            idx_d   = '0;
            phase_d = PH_FLAGS;
            pos_d   = '0;
          end else begin
            idx_d   = idx_c + FLAG_IDX_W'(1);
            phase_d = PH_TOKEN;
          end
          if (prod_next >= target_c) begin
            done_d  = 1'b1;
            phase_d = PH_DONE;
          end
        end
      end
    end
  end

  // Command to the copy engine
  always_comb begin
    cmd_o.valid   = tok_done;
    cmd_o.literal = tok_lit;
    cmd_o.data    = in_byte_i;
    cmd_o.offset  = off_c;
    cmd_o.length  = tok_n;
    cmd_o.base    = prod_c;
    cmd_o.target  = target_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SKIP;
      pos_q    <= '0;
      target_q <= '0;
      prod_q   <= '0;
      flag_q   <= '0;
      idx_q    <= '0;
      off_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      target_q <= target_d;
      prod_q   <= prod_d;
      flag_q   <= flag_d;
      idx_q    <= idx_d;
      off_q    <= off_d;
      done_q   <= done_d;
    end
  end

endmodule

/* rtl/lzss_copy.sv */
// ----------------------------------------------------------------------------
// LZSS copy engine
// Writes literals, replays matches byte by byte through the history memory,
// packs bytes into lanes and holds the output register.
// ----------------------------------------------------------------------------
module lzss_copy #(
  parameter int unsigned BytesPerResult = lzss_pkg::BYTES_PER_RESULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  lzss_pkg::tok_cmd_t            cmd_i,
  output logic                          idle_o,
  output lzss_pkg::hist_req_t           hist_o,
  input  logic [lzss_pkg::BYTE_W-1:0]   hist_rdata_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output lzss_pkg::res_t                res_o
);
  import lzss_pkg::*;

  localparam int unsigned Lanes   = (BytesPerResult > OUT_LANES) ? OUT_LANES :
                                    ((BytesPerResult < 1) ? 1 : BytesPerResult);
  localparam int unsigned LaneW   = $clog2(Lanes + 1);
  localparam int unsigned LaneIdxW = (Lanes > 1) ? $clog2(Lanes) : 1;
  localparam logic [LaneW:0] LanesC = (LaneW + 1)'(Lanes);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_COPY = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [HIST_AW-1:0] wp_q, wp_d;
  logic [BYTE_W-1:0]  last_q, last_d;
  logic [BYTE_W-1:0]  off_q, off_d;
  logic [BYTE_W-1:0]  remain_q, remain_d;
  logic               pend_q, pend_d;
  logic [BYTE_W-1:0]  lane_q [Lanes];
  logic [BYTE_W-1:0]  lane_d [Lanes];
  logic [LaneW-1:0]   lane_cnt_q, lane_cnt_d;
  logic [SIZE_W-1:0]  run_q, run_d;
  logic [SIZE_W-1:0]  target_q, target_d;
  res_t               res_q, res_d;
  logic               res_valid_q, res_valid_d;

  logic                             out_free;
  logic                             push;
  logic                             issue;
  logic [BYTE_W-1:0]                land_byte;
  logic [OUT_LANES-1:0][BYTE_W-1:0] push_data;

  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign out_free    = !res_valid_q || res_ready_i;

  // Offset zero gives zeros, offset one repeats the last byte written
  assign land_byte = (off_q == '0)          ? '0     :
                     (off_q == BYTE_W'(1))  ? last_q : hist_rdata_i;

  // Ship a lane group once it is full or the token has run out
  assign push  = (state_q == ST_COPY) && !pend_q && (lane_cnt_q != '0) &&
                 ((lane_cnt_q == LaneW'(Lanes)) || (remain_q == '0)) && out_free;
  assign issue = (state_q == ST_COPY) && (remain_q != '0) &&
                 (push || (({1'b0, lane_cnt_q} + (LaneW + 1)'(pend_q)) < LanesC));

  // Mask lanes past the byte count
  always_comb begin
    push_data = '0;
    for (int k = 0; k < Lanes; k++) begin
      if (LaneW'(k) < lane_cnt_q) begin
        push_data[k] = lane_q[k];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    last_d      = last_q;
    off_d       = off_q;
    remain_d    = remain_q;
    pend_d      = 1'b0;
    lane_d      = lane_q;
    lane_cnt_d  = lane_cnt_q;
    run_d       = run_q;
    target_d    = target_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    hist_o      = '0;

    // Release the output register when taken
    if (res_valid_q && res_ready_i) begin
      res_valid_d = 1'b0;
    end

    if (clear_i) begin
      wp_d   = '0;
      last_d = '0;
    end

    case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          target_d = cmd_i.target;
          if (cmd_i.literal) begin
            hist_o.we    = 1'b1;
            hist_o.waddr = wp_q;
            hist_o.wdata = cmd_i.data;
            wp_d         = wp_q + HIST_AW'(1);
            last_d       = cmd_i.data;
            lane_d[0]    = cmd_i.data;
            lane_cnt_d   = LaneW'(1);
            remain_d     = '0;
            run_d        = (cmd_i.base == '1) ? cmd_i.base : cmd_i.base + SIZE_W'(1);
            state_d      = ST_COPY;
          end else if (cmd_i.length != '0) begin
            off_d      = cmd_i.offset;
            remain_d   = cmd_i.length;
            lane_cnt_d = '0;
            run_d      = cmd_i.base;
            state_d    = ST_COPY;
          end
        end
      end
      ST_COPY: begin
        // Land the byte read last cycle
        if (pend_q) begin
          hist_o.we    = 1'b1;
          hist_o.waddr = wp_q;
          hist_o.wdata = land_byte;
          wp_d         = wp_q + HIST_AW'(1);
          last_d       = land_byte;
          lane_d[lane_cnt_q[LaneIdxW-1:0]] = land_byte;
          lane_cnt_d   = lane_cnt_q + LaneW'(1);
          run_d        = (run_q == '1) ? run_q : run_q + SIZE_W'(1);
        end
        // Read the source of the next byte
        if (issue) begin
          hist_o.re    = 1'b1;
          hist_o.raddr = wp_q + HIST_AW'(pend_q) - off_q;
          remain_d     = remain_q - BYTE_W'(1);
          pend_d       = 1'b1;
        end
        // Move the lane group to the output register
        if (push) begin
          res_d.data  = push_data;
          res_d.count = CNT_W'(lane_cnt_q);
          res_d.last  = (remain_q == '0);
          res_d.done  = (run_q >= target_q);
          res_valid_d = 1'b1;
          lane_cnt_d  = '0;
          if (remain_q == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      last_q      <= '0;
      remain_q    <= '0;
      pend_q      <= 1'b0;
      lane_cnt_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      last_q      <= last_d;
      remain_q    <= remain_d;
      pend_q      <= pend_d;
      lane_cnt_q  <= lane_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    off_q    <= off_d;
    lane_q   <= lane_d;
    run_q    <= run_d;
    target_q <= target_d;
    res_q    <= res_d;
  end

endmodule

/* tb/lzss_flag_word_decompressor_top_test.sv */
// ----------------------------------------------------------------------------
// LZSS flag-word decompressor testbench
// Feeds framed compressed streams byte by byte, with random gaps on both
// channels, and checks every packed output transaction against a predictor.
// ----------------------------------------------------------------------------
module lzss_flag_word_decompressor_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lzss_pkg::*;

  localparam int RESET_CYCLES       = 7;
  localparam int ITEM_TARGET        = 450;
  localparam int HOLD_AT_ITEM       = 150;
  localparam int PAUSE_AT_ITEM      = 300;
  localparam int OUTPUT_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES      = 64;
  // Longest quiet stretch of a correct run is the output hold plus a few
  // cycles of match start-up; take that several times over.
  localparam int WATCHDOG_LIMIT     = 3000;
  localparam int DIRECTED_ROWS      = 26;

  // Parser phases of the predictor
  typedef enum logic [2:0] {
    PH_HEADER, PH_SIZE_FIELD, PH_FLAG_WORD, PH_TOKEN_HEAD, PH_MATCH_LEN, PH_FINISHED
  } parse_phase_e;

  // One packed output transaction, lanes[0] is data_0
  typedef struct packed {
    logic [0:3][BYTE_W-1:0] lanes;
    logic [CNT_W-1:0]       count;
    logic                   last;
    logic                   done;
  } out_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              restart;
    logic              typed;
    out_word_t         word;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lzss_in_if  in_if ();
  lzss_out_if out_if ();

  lzss_flag_word_decompressor_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Decoder state of the predictor
  parse_phase_e      dec_phase;
  logic [2:0]        dec_hdr_pos;
  logic [31:0]       dec_target;
  logic [31:0]       dec_produced;
  logic [15:0]       dec_flags;
  logic [3:0]        dec_flag_idx;
  logic [7:0]        dec_offset;
  logic [7:0]        dec_history [HIST_DEPTH];
  logic [7:0]        dec_wr_ptr;
  bit                dec_finished;

  out_word_t         fresh_words [$];
  out_word_t         expected_words [$];
  logic [7:0]        stream_bytes [$];

  int                error_count;
  int                consumed_items;
  int                offered_items;
  int                checked_words;
  int                streams_sent;
  int                longest_match;
  int                idle_cycles;
  bit                sender_calm;
  bit                hold_output_req;

  // Directed part: two short streams covering the field extremes and the
  // special cases; typed expectations only where they are obvious.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    // stream with declared size zero: header, size, flags all literal
    '{8'h11, 1'b1, 1'b0, '0},
    '{8'h22, 1'b0, 1'b0, '0},
    '{8'h33, 1'b0, 1'b0, '0},
    '{8'h44, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    // first token is still decoded and ends the stream
    '{8'hFF, 1'b0, 1'b1, '{'{8'hFF, 8'h00, 8'h00, 8'h00}, 3'd1, 1'b1, 1'b1}},
    // byte after the end is dropped
    '{8'hA5, 1'b0, 1'b0, '0},
    // stream with maximum size and all-match flags
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    // reference before the stream start reads cleared history
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'h04, 1'b0, 1'b1, '{'{8'h00, 8'h00, 8'h00, 8'h00}, 3'd4, 1'b1, 1'b0}},
    // zero offset with zero length: token consumed, nothing out
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}
  };

  function automatic void clear_decoder();
    dec_phase    = PH_HEADER;
    dec_hdr_pos  = '0;
    dec_target   = '0;
    dec_produced = '0;
    dec_flags    = '0;
    dec_flag_idx = '0;
    dec_offset   = '0;
    dec_wr_ptr   = '0;
    dec_finished = 1'b0;
    foreach (dec_history[k]) dec_history[k] = '0;
  endfunction

  function automatic void store_history(input logic [7:0] value);
    dec_history[dec_wr_ptr] = value;
    dec_wr_ptr = dec_wr_ptr + 8'd1;
  endfunction

  // Advance the decoder by one compressed byte; leave its output in fresh_words
  task automatic decode_byte(input logic [7:0] value, input logic restart,
                             output bit consumed);
    logic [7:0]  run [$];
    logic [7:0]  src;
    logic [7:0]  copied;
    logic [32:0] sum;
    logic [31:0] base;
    int          n;
    int          cnt;
    bit          token_done;
    out_word_t   w;
    fresh_words.delete();
    if (restart) clear_decoder();
    consumed = !dec_finished;
    token_done = 1'b0;
    if (!dec_finished) begin
      case (dec_phase)
        PH_HEADER: begin
          dec_hdr_pos = dec_hdr_pos + 3'd1;
          if (dec_hdr_pos >= HDR_SKIP_BYTES) begin
            dec_phase = PH_SIZE_FIELD;
            dec_hdr_pos = '0;
          end
        end
        PH_SIZE_FIELD: begin
          if (dec_hdr_pos == '0) dec_target = '0;
          dec_target = dec_target | (32'(value) << (8 * dec_hdr_pos[1:0]));
          dec_hdr_pos = dec_hdr_pos + 3'd1;
          if (dec_hdr_pos >= SIZE_BYTES) begin
            dec_phase = PH_FLAG_WORD;
            dec_hdr_pos = '0;
          end
        end
        PH_FLAG_WORD: begin
          if (dec_hdr_pos == '0) begin
            dec_flags = {8'h00, value};
            dec_hdr_pos = 3'd1;
          end else begin
            dec_flags[15:8] = value;
            dec_hdr_pos = '0;
            dec_flag_idx = '0;
            dec_phase = PH_TOKEN_HEAD;
          end
        end
        PH_TOKEN_HEAD: begin
          if (dec_flags[dec_flag_idx]) begin
            dec_offset = value;
            dec_phase = PH_MATCH_LEN;
          end else begin
            run.push_back(value);
            store_history(value);
            token_done = 1'b1;
          end
        end
        PH_MATCH_LEN: begin
          // copy one byte at a time so short offsets repeat a run
          for (int i = 0; i < int'(value); i++) begin
            src = dec_wr_ptr - dec_offset;
            copied = (dec_offset != 8'd0) ? dec_history[src] : 8'h00;
            run.push_back(copied);
            store_history(copied);
          end
          if (int'(value) > longest_match) longest_match = int'(value);
          token_done = 1'b1;
        end
        default: begin
          dec_finished = 1'b1;
          dec_phase = PH_FINISHED;
        end
      endcase
    end

    if (token_done) begin
      n = run.size();
      base = dec_produced;
      sum = {1'b0, base} + 33'(n);
      dec_produced = sum[32] ? '1 : sum[31:0];
      if (dec_flag_idx >= FLAG_LAST_IDX) begin
        dec_flag_idx = '0;
        dec_phase = PH_FLAG_WORD;
        dec_hdr_pos = '0;
      end else begin
        dec_flag_idx = dec_flag_idx + 4'd1;
        dec_phase = PH_TOKEN_HEAD;
      end
      if (dec_produced >= dec_target) begin
        dec_finished = 1'b1;
        dec_phase = PH_FINISHED;
      end
      // pack the token output into transactions of up to four lanes
      for (int i = 0; i < n; i += OUT_LANES) begin
        cnt = (n - i > int'(OUT_LANES)) ? int'(OUT_LANES) : n - i;
        w = '0;
        for (int j = 0; j < cnt; j++) w.lanes[j] = run[i + j];
        w.count = CNT_W'(cnt);
        w.last = (i + cnt >= n);
        w.done = (64'(base) + 64'(i + cnt) >= 64'(dec_target));
        fresh_words.push_back(w);
      end
    end
  endtask

  // Mostly no gap, some short ones, a few long ones
  function automatic int idle_gap(input bit calm);
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Offer one byte, hold until the transaction, then queue its expectations
  task automatic offer_byte(input logic [7:0] value, input logic restart,
                            input bit typed, input out_word_t typed_word);
    int gap;
    bit consumed;
    gap = idle_gap(sender_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.in_byte    <= value;
    in_if.new_stream <= restart;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    decode_byte(value, restart, consumed);
    if (consumed) consumed_items++;
    offered_items++;
    if (typed) expected_words.push_back(typed_word);
    else foreach (fresh_words[k]) expected_words.push_back(fresh_words[k]);
  endtask

  // Build one well-formed stream with random content into stream_bytes
  task automatic compose_stream();
    int          n_tokens;
    int          total;
    int          len;
    int          pick;
    logic [15:0] flags;
    logic [7:0]  offset;
    logic [7:0]  body [$];
    logic [31:0] size_field;
    pick = $urandom_range(0, 9);
    n_tokens = (pick < 2) ? 16 : (pick < 3) ? 32 : $urandom_range(1, 24);
    total = 0;
    flags = '0;
    for (int t = 0; t < n_tokens; t++) begin
      if (t % 16 == 0) begin
        flags = 16'($urandom());
        body.push_back(flags[7:0]);
        body.push_back(flags[15:8]);
      end
      if (flags[t % 16]) begin
        // offsets lean short so runs repeat; lengths lean short, a few long
        pick = $urandom_range(0, 99);
        offset = (pick < 6) ? 8'd0 : (pick < 50) ? 8'($urandom_range(1, 4))
                                                 : 8'($urandom_range(1, 255));
        pick = $urandom_range(0, 99);
        len = (pick < 3) ? $urandom_range(64, 255) : (pick < 8) ? 0 : $urandom_range(1, 12);
        body.push_back(offset);
        body.push_back(8'(len));
        total += len;
      end else begin
        body.push_back(8'($urandom_range(0, 255)));
        total++;
      end
    end
    // size mostly matches the tokens; sometimes short, zero, maximum or too long
    pick = $urandom_range(0, 19);
    if (pick < 13) size_field = 32'(total);
    else if (pick < 15) size_field = 32'($urandom_range(0, total));
    else if (pick < 16) size_field = '0;
    else if (pick < 17) size_field = '1;
    else size_field = 32'(total + $urandom_range(1, 50));
    stream_bytes.delete();
    repeat (HDR_SKIP_BYTES) stream_bytes.push_back(8'($urandom()));
    for (int k = 0; k < int'(SIZE_BYTES); k++) stream_bytes.push_back(size_field[8*k +: 8]);
    foreach (body[k]) stream_bytes.push_back(body[k]);
    repeat ($urandom_range(0, 4)) stream_bytes.push_back(8'($urandom()));
    // cut a stream short now and then; the next restart breaks into it
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, stream_bytes.size());
      while (stream_bytes.size() > len) void'(stream_bytes.pop_back());
    end
  endtask

  // Compare each output transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    out_word_t got;
    out_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      checked_words++;
      got.lanes = {out_if.data_0, out_if.data_1, out_if.data_2, out_if.data_3};
      got.count = out_if.byte_count;
      got.last  = out_if.run_last;
      got.done  = out_if.stream_done;
      if (expected_words.size() == 0) begin
        report_mismatch("transaction with nothing expected", 32'(got), '0);
      end else begin
        want = expected_words.pop_front();
        for (int j = 0; j < int'(OUT_LANES); j++) begin
          if (got.lanes[j] !== want.lanes[j])
            report_mismatch($sformatf("data_%0d", j), 32'(got.lanes[j]), 32'(want.lanes[j]));
        end
        if (got.count !== want.count)
          report_mismatch("byte_count", 32'(got.count), 32'(want.count));
        if (got.last !== want.last)
          report_mismatch("run_last", 32'(got.last), 32'(want.last));
        if (got.done !== want.done)
          report_mismatch("stream_done", 32'(got.done), 32'(want.done));
      end
    end
  end

  // End the run when neither channel moves for too long
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, idle_cycles);
      $display("lzss_flag_word_decompressor_top_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Output side: random back-pressure, calm stretches, one long hold-off
  initial begin : output_side
    int gap;
    int mode_left;
    bit calm;
    mode_left = 0;
    calm = 1'b0;
    out_if.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_output_req) begin
        out_if.ready <= 1'b0;
        repeat (OUTPUT_HOLD_CYCLES) @(posedge clk_i);
        hold_output_req = 1'b0;
      end else begin
        if (mode_left <= 0) begin
          calm = ($urandom_range(0, 3) == 0);
          mode_left = $urandom_range(50, 300);
        end
        gap = idle_gap(calm);
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        mode_left -= gap;
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      mode_left--;
    end
  end

  // Input side: reset, directed table, then random streams
  initial begin : input_side
    bit hold_asked;
    bit pause_done;
    int burst;
    hold_asked = 1'b0;
    pause_done = 1'b0;
    error_count = 0;
    consumed_items = 0;
    offered_items = 0;
    checked_words = 0;
    streams_sent = 0;
    longest_match = 0;
    sender_calm = 1'b0;
    hold_output_req = 1'b0;
    in_if.valid      <= 1'b0;
    in_if.in_byte    <= '0;
    in_if.new_stream <= 1'b0;
    clear_decoder();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (directed_rows[k])
      offer_byte(directed_rows[k].value, directed_rows[k].restart,
                 directed_rows[k].typed, directed_rows[k].word);
    streams_sent += 2;
    consumed_items = 0;

    while (offered_items < ITEM_TARGET) begin
      // Drain to idle once: stop offering until every result is back
      if (!pause_done && offered_items >= PAUSE_AT_ITEM) begin
        pause_done = 1'b1;
        in_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk_i);
        repeat (SETTLE_CYCLES) @(posedge clk_i);
      end
      sender_calm = ($urandom_range(0, 3) == 0);
      // Hold the output once while input keeps coming, so the block backs up
      if (!hold_asked && offered_items >= HOLD_AT_ITEM) begin
        hold_asked = 1'b1;
        hold_output_req = 1'b1;
        sender_calm = 1'b1;
      end
      if ($urandom_range(0, 11) == 0) begin
        // noise: random bytes, some of them restarting the parse
        burst = $urandom_range(1, 6);
        repeat (burst) offer_byte(8'($urandom()), ($urandom_range(0, 3) == 0), 1'b0, '0);
      end else begin
        compose_stream();
        foreach (stream_bytes[k]) offer_byte(stream_bytes[k], (k == 0), 1'b0, '0);
        streams_sent++;
      end
    end

    // Drain and settle
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("run covered %0d bytes offered in %0d streams, %0d decoded after the table",
             offered_items, streams_sent, consumed_items);
    $display("%0d output transactions checked, longest match %0d bytes, %0d mismatches",
             checked_words, longest_match, error_count);
    if (error_count == 0) begin
      $display("lzss_flag_word_decompressor_top_test: clean");
    end else begin
      $display("lzss_flag_word_decompressor_top_test: errors");
    end
    $finish;
  end

endmodule
